// ===== design/rdi_pkg.sv =====
// Types and constants for the RTCP deterministic interval block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rdi_pkg;

  localparam int unsigned DivBits  = 48;        // quotient bits produced by the cell row
  localparam logic [16:0] OneQ16   = 17'd65536;
  localparam logic [31:0] MinReset = 32'd327680; // five seconds, Q16.16
  localparam logic [47:0] Max48    = {48{1'b1}};

  typedef struct packed {
    logic [15:0] member_count;
    logic [15:0] sender_count;
    logic [31:0] report_bandwidth;
    logic [16:0] sender_share;
    logic        we_are_sender;
    logic [19:0] average_size;
    logic        first_report;
  } in_t;

  typedef struct packed {
    logic [47:0] interval;
    logic [47:0] used_bandwidth;
    logic [15:0] used_members;
  } out_t;

  // Data that rides alongside the division
  typedef struct packed {
    logic [47:0] eff_bw;
    logic [15:0] members;
    logic        first;
    logic        ovf;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic [DivBits-1:0] rem;
    logic [DivBits-1:0] numer;
    logic [DivBits-1:0] quot;
    logic [DivBits-1:0] divisor;
    side_t              side;
  } cell_t;

endpackage

// ===== design/rdi_front.sv =====
// Front pipeline: share test, bandwidth scaling, numerator product, overflow check.
// Depends on rdi_pkg; feeds the first rdi_cell.
`timescale 1ns / 1ps

module rdi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_take,
  input  rdi_pkg::in_t   in_item,
  output rdi_pkg::cell_t cell_o
);

  logic         s1_v_r;
  rdi_pkg::in_t s1_r;

  logic         s2_v_r;
  rdi_pkg::in_t s2_r;
  logic [16:0]  s2_share_r;
  logic [32:0]  s2_prod_r;

  logic         s3_v_r;
  logic [31:0]  s3_bw_r;
  logic [16:0]  s3_fac_r;
  logic [15:0]  s3_n_r;
  logic [19:0]  s3_avg_r;
  logic         s3_first_r;

  logic         s4_v_r;
  logic [47:0]  s4_eff_r;
  logic [35:0]  s4_p_r;
  logic [15:0]  s4_n_r;
  logic         s4_first_r;

  rdi_pkg::cell_t cell_r;

  logic [16:0] share_c;
  logic        cond;
  logic [16:0] fac_nxt;
  logic [15:0] n_nxt;
  logic [48:0] eff_full;
  logic        ovf;

  assign share_c = (s1_r.sender_share > rdi_pkg::OneQ16) ? rdi_pkg::OneQ16
                                                         : s1_r.sender_share;

  always_comb begin
    cond    = {1'b0, s2_r.sender_count, 16'd0} <= s2_prod_r;
    fac_nxt = rdi_pkg::OneQ16;
    n_nxt   = s2_r.member_count;
    if (cond) begin
      if (s2_r.we_are_sender) begin
        fac_nxt = s2_share_r;
        n_nxt   = s2_r.sender_count;
      end else begin
        fac_nxt = rdi_pkg::OneQ16 - s2_share_r;
        n_nxt   = s2_r.member_count - s2_r.sender_count;
      end
    end
  end

  assign eff_full = s3_bw_r * s3_fac_r;
  // quotient would not fit 48 bits: p*2^28 >= eff*2^48
  assign ovf = (s4_eff_r != 48'd0) && ({32'd0, s4_p_r} >= {s4_eff_r, 20'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= s4_v_r;
    end
    s1_r       <= in_item;
    s2_r       <= s1_r;
    s2_share_r <= share_c;
    s2_prod_r  <= s1_r.member_count * share_c;
    s3_bw_r    <= s2_r.report_bandwidth;
    s3_fac_r   <= fac_nxt;
    s3_n_r     <= n_nxt;
    s3_avg_r   <= s2_r.average_size;
    s3_first_r <= s2_r.first_report;
    s4_eff_r   <= eff_full[47:0];
    s4_p_r     <= s3_avg_r * s3_n_r;
    s4_n_r     <= s3_n_r;
    s4_first_r <= s3_first_r;
    cell_r.rem          <= {32'd0, s4_p_r[35:20]};
    cell_r.numer        <= {s4_p_r[19:0], 28'd0};
    cell_r.quot         <= '0;
    cell_r.divisor      <= s4_eff_r;
    cell_r.side.eff_bw  <= s4_eff_r;
    cell_r.side.members <= s4_n_r;
    cell_r.side.first   <= s4_first_r;
    cell_r.side.ovf     <= ovf;
    cell_r.side.zero    <= (s4_eff_r == 48'd0);
  end

  assign cell_o = cell_r;

endmodule

// ===== design/rdi_cell.sv =====
// One restoring division step: brings in a numerator bit, yields one quotient bit.
// Depends on rdi_pkg; chained in the top level.
`timescale 1ns / 1ps

module rdi_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rdi_pkg::cell_t cell_i,
  output rdi_pkg::cell_t cell_o
);

  rdi_pkg::cell_t cell_r;
  logic [rdi_pkg::DivBits:0]   trial;
  logic [rdi_pkg::DivBits:0]   diff;
  logic                        ge;
  logic [rdi_pkg::DivBits-1:0] rem_nxt;

  always_comb begin
    trial   = {cell_i.rem, cell_i.numer[rdi_pkg::DivBits-1]};
    diff    = trial - {1'b0, cell_i.divisor};
    ge      = trial >= {1'b0, cell_i.divisor};
    rem_nxt = ge ? diff[rdi_pkg::DivBits-1:0] : trial[rdi_pkg::DivBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_i.valid;
    end
    cell_r.rem     <= rem_nxt;
    cell_r.numer   <= {cell_i.numer[rdi_pkg::DivBits-2:0], 1'b0};
    cell_r.quot    <= {cell_i.quot[rdi_pkg::DivBits-2:0], ge};
    cell_r.divisor <= cell_i.divisor;
    cell_r.side    <= cell_i.side;
  end

  assign cell_o = cell_r;

endmodule

// ===== design/rtcp_deterministic_interval.sv =====
// RTCP deterministic report interval, top level.
// Path: an accepted transaction passes the 5 front stages, the 48-cell divider row and
// the output register before the result strobe rises.
// Throughput: one transaction per cycle, busy is never raised.
// Reset (rst_n low, synchronous) empties the pipeline and sets min_interval to 5 s.
// Depends on rdi_pkg, rdi_front, rdi_cell.
`timescale 1ns / 1ps

module rtcp_deterministic_interval (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rdi_pkg::in_t  in_item,
  output logic          out_valid,
  output rdi_pkg::out_t out_result,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  rdi_pkg::cell_t chain [0:rdi_pkg::DivBits];
  logic [31:0]    min_interval_r;
  logic           out_valid_r;
  rdi_pkg::out_t  out_result_r;
  rdi_pkg::cell_t last;
  logic [47:0]    t;
  logic [47:0]    floor_t;

  assign busy = 1'b0;

  rdi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_take(start & ~busy),
    .in_item(in_item),
    .cell_o (chain[0])
  );

  for (genvar i = 0; i < rdi_pkg::DivBits; i++) begin : g_cell
    rdi_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cell_i(chain[i]),
      .cell_o(chain[i+1])
    );
  end

  assign last = chain[rdi_pkg::DivBits];

  always_comb begin
    if (last.side.zero) begin
      t = 48'd0;
    end else if (last.side.ovf) begin
      t = rdi_pkg::Max48;
    end else begin
      t = last.quot;
    end
    floor_t = last.side.first ? {17'd0, min_interval_r[31:1]} : {16'd0, min_interval_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= rdi_pkg::MinReset;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_interval_r <= cfg_wdata;
      end
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r.interval       <= (t < floor_t) ? floor_t : t;
    out_result_r.used_bandwidth <= last.side.eff_bw;
    out_result_r.used_members   <= last.side.members;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== design/rdi_checker.sv =====
// Port-level checks for rtcp_deterministic_interval, bound to the top level.
// Depends on rdi_pkg.
`timescale 1ns / 1ps

module rdi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input rdi_pkg::out_t out_result
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##54 out_valid)
    else $error("transaction lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 54))
    else $error("result without transaction");

  a_known_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_result))
    else $error("unknown result bits");

endmodule

bind rtcp_deterministic_interval rdi_checker u_rdi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_result(out_result)
);
